>>> hw/rtl/hdu_pkg.sv
// ----------------------------------------------------------------------------
// hdu_pkg
// Shared types, fixed-point constants and elaboration-time table builders
// for the haversine distance unit and its CORDIC pipelines.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hdu_pkg;

   localparam int ITER_CAP = 40;
   localparam int XY_W     = 44;   // Q40 datapath plus growth and sign
   localparam int Z_W      = 64;   // Q60 radians, signed

   typedef logic signed [XY_W-1:0] xy_type;
   typedef logic signed [Z_W-1:0]  z_type;

   localparam logic [63:0] ONE_Q60 = 64'd1 << 60;

   // degree-to-turn conversion: turn = (mag * 2^k + 1757812) / 3515625
   localparam logic [21:0] DEG_DIV    = 22'd3515625;
   localparam logic [20:0] TURN_BIAS  = 21'd1757812;
   localparam logic [32:0] TURN_RECIP = 33'd5124095576;   // floor(2^54 / DEG_DIV)

   // shift-subtract divide, used only while building constants
   function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // atan(1/n) in Q60 from the truncated Taylor series
   function automatic logic [63:0] atan_recip(input logic [63:0] n);
      logic [63:0] p;
      logic [63:0] sum;
      logic [63:0] term;
      logic [63:0] k;
      p   = long_div(ONE_Q60, n);
      sum = '0;
      k   = '0;
      while (p != 64'd0) begin
         term = long_div(p, 64'd2 * k + 64'd1);
         if (k[0]) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
         p = long_div(long_div(p, n), n);
         k = k + 64'd1;
      end
      return sum;
   endfunction

   function automatic logic [63:0] atan_q60(input int idx);
      if (idx == 0) begin
         return atan_recip(64'd2) + atan_recip(64'd3);
      end
      return atan_recip(64'd1 << idx);
   endfunction

   function automatic logic [31:0] pi_q30();
      logic [63:0] v;
      v = (64'd4 * atan_q60(0) + (64'd1 << 29)) >> 30;
      return v[31:0];
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] val);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bt;
      v   = val;
      res = '0;
      bt  = 64'd1 << 62;
      while (bt > v) begin
         bt = bt >> 2;
      end
      while (bt != 64'd0) begin
         if (v >= res + bt) begin
            v   = v - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt = bt >> 2;
      end
      return res;
   endfunction

   // CORDIC gain in Q30 for n rotation steps
   function automatic logic [63:0] gain_q30(input int n);
      logic [63:0] kk;
      kk = ONE_Q60;
      for (int i = 0; i < n; i++) begin
         if (2 * i < 62) begin
            kk = kk - long_div(kk, (64'd1 << (2 * i)) + 64'd1);
         end
      end
      return isqrt64(kk);
   endfunction

endpackage

>>> hw/rtl/hdu_cordic.sv
// ----------------------------------------------------------------------------
// hdu_cordic
// Fully unrolled CORDIC, one register stage per iteration. Rotation mode
// drives z to zero; vectoring mode drives y to zero. A tag rides along.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hdu_cordic #(
   parameter int ITERATIONS = 24,
   parameter bit VECTORING  = 1'b0,
   parameter int TAG_W      = 2
) (
   input  logic                 clock,
   input  logic                 enable,
   input  hdu_pkg::xy_type      src_x,
   input  hdu_pkg::xy_type      src_y,
   input  hdu_pkg::z_type       src_z,
   input  logic [TAG_W-1:0]     src_tag,
   output hdu_pkg::xy_type      dst_x,
   output hdu_pkg::xy_type      dst_y,
   output hdu_pkg::z_type       dst_z,
   output logic [TAG_W-1:0]     dst_tag
);

   hdu_pkg::xy_type  x_ff   [1:ITERATIONS];
   hdu_pkg::xy_type  y_ff   [1:ITERATIONS];
   hdu_pkg::z_type   z_ff   [1:ITERATIONS];
   logic [TAG_W-1:0] tag_ff [1:ITERATIONS];

   hdu_pkg::xy_type  x_cur   [0:ITERATIONS-1];
   hdu_pkg::xy_type  y_cur   [0:ITERATIONS-1];
   hdu_pkg::z_type   z_cur   [0:ITERATIONS-1];
   logic [TAG_W-1:0] tag_cur [0:ITERATIONS-1];

   hdu_pkg::xy_type  x_in [0:ITERATIONS-1];
   hdu_pkg::xy_type  y_in [0:ITERATIONS-1];
   hdu_pkg::z_type   z_in [0:ITERATIONS-1];

   hdu_pkg::z_type   angle [0:ITERATIONS-1];

   for (genvar i = 0; i < ITERATIONS; i++) begin : g_angle
      localparam logic [63:0] ANGLE_Q60 = hdu_pkg::atan_q60(i);
      assign angle[i] = hdu_pkg::z_type'(ANGLE_Q60);
   end

   always_comb begin
      x_cur[0]   = src_x;
      y_cur[0]   = src_y;
      z_cur[0]   = src_z;
      tag_cur[0] = src_tag;
      for (int i = 1; i < ITERATIONS; i++) begin
         x_cur[i]   = x_ff[i];
         y_cur[i]   = y_ff[i];
         z_cur[i]   = z_ff[i];
         tag_cur[i] = tag_ff[i];
      end
   end

   // each stage only looks at its own register set
   always_comb begin
      for (int i = 0; i < ITERATIONS; i++) begin
         if (VECTORING ? (y_cur[i] < 0) : (z_cur[i] >= 0)) begin
            x_in[i] = x_cur[i] - (y_cur[i] >>> i);
            y_in[i] = y_cur[i] + (x_cur[i] >>> i);
            z_in[i] = z_cur[i] - angle[i];
         end else begin
            x_in[i] = x_cur[i] + (y_cur[i] >>> i);
            y_in[i] = y_cur[i] - (x_cur[i] >>> i);
            z_in[i] = z_cur[i] + angle[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < ITERATIONS; i++) begin
            x_ff[i+1]   <= x_in[i];
            y_ff[i+1]   <= y_in[i];
            z_ff[i+1]   <= z_in[i];
            tag_ff[i+1] <= tag_cur[i];
         end
      end
   end

   assign dst_x   = x_ff[ITERATIONS];
   assign dst_y   = y_ff[ITERATIONS];
   assign dst_z   = z_ff[ITERATIONS];
   assign dst_tag = tag_ff[ITERATIONS];

endmodule

>>> hw/rtl/haversine_distance_unit.sv
// Throughput: one item per cycle while no stalled result holds the pipe;
// every stage is registered and fully pipelined.
// The long pole is the two unrolled CORDIC chains plus the 32-step square root.
// A stalled result freezes the whole pipe; nothing is dropped or repeated.
// Reset (sync, active high) empties the pipe and sets the radius to 6371000 m.
// ----------------------------------------------------------------------------
// haversine_distance_unit
// Great-circle distance between two lat/lon points by the haversine formula,
// in fixed point, rounded to whole metres.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module haversine_distance_unit #(
   parameter int CORDIC_ITERATIONS = 24
) (
   input  logic               clock,
   input  logic               reset,
   // item input
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [30:0] req_first_latitude,
   input  logic signed [31:0] req_first_longitude,
   input  logic signed [30:0] req_second_latitude,
   input  logic signed [31:0] req_second_longitude,
   // result output
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [24:0]        rsp_distance_metres,
   // radius register
   input  logic               csr_write_enable,
   input  logic [22:0]        csr_write_data
);

   // Pipeline map (one register each unless noted):
   //   s0   input capture
   //   s1   |angle| scaled to a turn numerator, sign kept aside
   //   s2   numerator * reciprocal, two 27x33 partial products
   //   s3   partial products summed -> quotient estimate
   //   s4   estimate * divisor (low bits only)
   //   s5   remainder check bumps estimate by one, sign applied -> 32-bit turn
   //   s6   quadrant split, remainder -> Q60 radians
   //   rot  CORDIC rotation, four lanes (lat1, lat2, dlat/2, dlon/2)
   //   s7   round/clamp to Q30, quadrant fold -> cos1, cos2, sin(dlat/2), sin(dlon/2)
   //   s8   c1*c2, s1*s1
   //   s9   t*s2
   //   s10  u*s2
   //   s11  a = s1^2 + u*s2, clamped to [0, 1]
   //   sqrt 32 steps, two lanes (a and 1-a)
   //   vec  CORDIC vectoring -> central angle / 2
   //   s12  angle rounded to Q36
   //   s13  radius * angle, two partial products
   //   out  sum, round to metres
   localparam int SQRT_STEPS = 32;
   localparam int LAT        = 2 * CORDIC_ITERATIONS + SQRT_STEPS + 15;

   localparam logic [31:0]     PI_Q30  = hdu_pkg::pi_q30();
   localparam logic [63:0]     GAIN    = hdu_pkg::gain_q30(CORDIC_ITERATIONS);
   localparam logic [63:0]     X_START = GAIN << 10;
   localparam hdu_pkg::xy_type XY_HALF = hdu_pkg::xy_type'(512);
   localparam hdu_pkg::xy_type Q30_POS = hdu_pkg::xy_type'(64'd1 << 30);
   localparam hdu_pkg::xy_type Q30_NEG = -Q30_POS;
   localparam logic signed [63:0] RND30 = 64'sh2000_0000;

   // ------------------------------------------------------------------
   // Flow control: a single enable; the output register is the last stage
   // ------------------------------------------------------------------
   logic             pipe_en;
   logic             vld_ff [0:LAT-1];
   logic [22:0]      radius_ff;

   assign pipe_en   = !(vld_ff[LAT-1] && rsp_stall);
   assign req_stall = !pipe_en;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (pipe_en) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k < LAT; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 23'd6371000;
      end else if (csr_write_enable) begin
         radius_ff <= csr_write_data;
      end
   end

   // ------------------------------------------------------------------
   // s0: capture
   // ------------------------------------------------------------------
   logic signed [30:0] lat1_s0_ff, lat2_s0_ff;
   logic signed [31:0] lon1_s0_ff, lon2_s0_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         lat1_s0_ff <= req_first_latitude;
         lon1_s0_ff <= req_first_longitude;
         lat2_s0_ff <= req_second_latitude;
         lon2_s0_ff <= req_second_longitude;
      end
   end

   // ------------------------------------------------------------------
   // s1..s5: 1e-7 degree -> binary turn, round half away from zero.
   // Lanes 0/1 are full latitudes, lanes 2/3 are half differences.
   // ------------------------------------------------------------------
   logic [53:0] num_in     [0:3];
   logic        neg_in     [0:3];
   logic [53:0] num_s1_ff  [0:3];
   logic        neg_s1_ff  [0:3];
   logic [59:0] ph_s2_ff   [0:3];
   logic [59:0] pl_s2_ff   [0:3];
   logic [22:0] nlo_s2_ff  [0:3];
   logic        neg_s2_ff  [0:3];
   logic [32:0] qe_in      [0:3];
   logic [32:0] qe_s3_ff   [0:3];
   logic [22:0] nlo_s3_ff  [0:3];
   logic        neg_s3_ff  [0:3];
   logic [22:0] md_in      [0:3];
   logic [22:0] md_s4_ff   [0:3];
   logic [31:0] qe_s4_ff   [0:3];
   logic [22:0] nlo_s4_ff  [0:3];
   logic        neg_s4_ff  [0:3];
   logic [31:0] turn_in    [0:3];
   logic [31:0] turn_s5_ff [0:3];
   logic [1:0]  quad_s6_ff [0:3];
   logic [60:0] z_in       [0:3];
   logic [60:0] z_s6_ff    [0:3];

   always_comb begin
      logic signed [33:0] span [0:3];
      logic [32:0]        mag;
      span[0] = 34'(lat1_s0_ff);
      span[1] = 34'(lat2_s0_ff);
      span[2] = 34'(lat2_s0_ff) - 34'(lat1_s0_ff);
      span[3] = 34'(lon2_s0_ff) - 34'(lon1_s0_ff);
      for (int k = 0; k < 4; k++) begin
         neg_in[k] = span[k][33];
         mag       = neg_in[k] ? 33'(-span[k]) : 33'(span[k]);
         num_in[k] = (54'(mag) << ((k < 2) ? 22 : 21)) + 54'(hdu_pkg::TURN_BIAS);
      end
   end

   always_comb begin
      logic [86:0] sum;
      logic [44:0] prod;
      logic [22:0] rem;
      logic [31:0] q;
      for (int k = 0; k < 4; k++) begin
         sum      = {ph_s2_ff[k], 27'b0} + 87'(pl_s2_ff[k]);
         qe_in[k] = sum[86:54];
         prod     = 45'(qe_s3_ff[k][22:0]) * 45'(hdu_pkg::DEG_DIV);
         md_in[k] = prod[22:0];
         // estimate is never more than one short of the true quotient
         rem        = nlo_s4_ff[k] - md_s4_ff[k];
         q          = qe_s4_ff[k] + 32'(rem >= 23'(hdu_pkg::DEG_DIV));
         turn_in[k] = neg_s4_ff[k] ? -q : q;
      end
   end

   always_comb begin
      logic [61:0] zp;
      for (int k = 0; k < 4; k++) begin
         zp      = 62'(turn_s5_ff[k][29:0]) * 62'(PI_Q30);
         z_in[k] = zp[61:1];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int k = 0; k < 4; k++) begin
            num_s1_ff[k]  <= num_in[k];
            neg_s1_ff[k]  <= neg_in[k];
            ph_s2_ff[k]   <= 60'(num_s1_ff[k][53:27]) * 60'(hdu_pkg::TURN_RECIP);
            pl_s2_ff[k]   <= 60'(num_s1_ff[k][26:0]) * 60'(hdu_pkg::TURN_RECIP);
            nlo_s2_ff[k]  <= num_s1_ff[k][22:0];
            neg_s2_ff[k]  <= neg_s1_ff[k];
            qe_s3_ff[k]   <= qe_in[k];
            nlo_s3_ff[k]  <= nlo_s2_ff[k];
            neg_s3_ff[k]  <= neg_s2_ff[k];
            md_s4_ff[k]   <= md_in[k];
            qe_s4_ff[k]   <= qe_s3_ff[k][31:0];
            nlo_s4_ff[k]  <= nlo_s3_ff[k];
            neg_s4_ff[k]  <= neg_s3_ff[k];
            turn_s5_ff[k] <= turn_in[k];
            quad_s6_ff[k] <= turn_s5_ff[k][31:30];
            z_s6_ff[k]    <= z_in[k];
         end
      end
   end

   // ------------------------------------------------------------------
   // Rotation CORDIC, one per lane
   // ------------------------------------------------------------------
   hdu_pkg::xy_type rot_x [0:3];
   hdu_pkg::xy_type rot_y [0:3];
   logic [1:0]      rot_q [0:3];

   for (genvar k = 0; k < 4; k++) begin : g_rot
      hdu_cordic #(
         .ITERATIONS (CORDIC_ITERATIONS),
         .VECTORING  (1'b0),
         .TAG_W      (2)
      ) u_rot (
         .clock   (clock),
         .enable  (pipe_en),
         .src_x   (hdu_pkg::xy_type'(X_START)),
         .src_y   ('0),
         .src_z   (hdu_pkg::z_type'(z_s6_ff[k])),
         .src_tag (quad_s6_ff[k]),
         .dst_x   (rot_x[k]),
         .dst_y   (rot_y[k]),
         .dst_z   (),
         .dst_tag (rot_q[k])
      );
   end

   // ------------------------------------------------------------------
   // s7: round to Q30, clamp to +-1, fold the quadrant back in
   // ------------------------------------------------------------------
   logic signed [31:0] trig_in    [0:3];
   logic signed [31:0] trig_s7_ff [0:3];

   always_comb begin
      hdu_pkg::xy_type    xr, yr, cc, ss;
      logic signed [31:0] c32, s32, cos_v, sin_v;
      for (int k = 0; k < 4; k++) begin
         xr = (rot_x[k] + XY_HALF) >>> 10;
         yr = (rot_y[k] + XY_HALF) >>> 10;
         cc = (xr > Q30_POS) ? Q30_POS : ((xr < Q30_NEG) ? Q30_NEG : xr);
         ss = (yr > Q30_POS) ? Q30_POS : ((yr < Q30_NEG) ? Q30_NEG : yr);
         c32 = 32'(cc);
         s32 = 32'(ss);
         case (rot_q[k])
            2'd0: begin
               cos_v = c32;
               sin_v = s32;
            end
            2'd1: begin
               cos_v = -s32;
               sin_v = c32;
            end
            2'd2: begin
               cos_v = -c32;
               sin_v = -s32;
            end
            default: begin
               cos_v = s32;
               sin_v = -c32;
            end
         endcase
         trig_in[k] = (k < 2) ? cos_v : sin_v;
      end
   end

   // ------------------------------------------------------------------
   // s8..s11: a = s1^2 + rnd(rnd(c1*c2)*s2)*s2, then clamp
   // ------------------------------------------------------------------
   logic signed [63:0] ccp_s8_ff, s1sq_s8_ff, up_s9_ff, s1sq_s9_ff;
   logic signed [63:0] us_s10_ff, s1sq_s10_ff;
   logic signed [31:0] s2_s8_ff, s2_s9_ff;
   logic signed [31:0] t_in, u_in;
   logic signed [63:0] tw, uw, a_sum;
   logic [60:0]        a_in;
   logic [63:0]        root_a_s11_ff, root_b_s11_ff;

   always_comb begin
      tw    = (ccp_s8_ff + RND30) >>> 30;
      t_in  = 32'(tw);
      uw    = (up_s9_ff + RND30) >>> 30;
      u_in  = 32'(uw);
      a_sum = s1sq_s10_ff + us_s10_ff;
      if (a_sum < 0) begin
         a_in = '0;
      end else if (a_sum > 64'sh1000_0000_0000_0000) begin
         a_in = 61'(hdu_pkg::ONE_Q60);
      end else begin
         a_in = 61'(a_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int k = 0; k < 4; k++) begin
            trig_s7_ff[k] <= trig_in[k];
         end
         ccp_s8_ff     <= 64'(trig_s7_ff[0]) * 64'(trig_s7_ff[1]);
         s1sq_s8_ff    <= 64'(trig_s7_ff[2]) * 64'(trig_s7_ff[2]);
         s2_s8_ff      <= trig_s7_ff[3];
         up_s9_ff      <= 64'(t_in) * 64'(s2_s8_ff);
         s1sq_s9_ff    <= s1sq_s8_ff;
         s2_s9_ff      <= s2_s8_ff;
         us_s10_ff     <= 64'(u_in) * 64'(s2_s9_ff);
         s1sq_s10_ff   <= s1sq_s9_ff;
         root_a_s11_ff <= 64'(a_in);
         root_b_s11_ff <= hdu_pkg::ONE_Q60 - 64'(a_in);
      end
   end

   // ------------------------------------------------------------------
   // Square roots: one result bit per stage, lane 0 = sqrt(a),
   // lane 1 = sqrt(1-a)
   // ------------------------------------------------------------------
   logic [63:0] sq_v_ff   [0:1][1:SQRT_STEPS];
   logic [63:0] sq_r_ff   [0:1][1:SQRT_STEPS];
   logic [63:0] sq_v_in   [0:1][0:SQRT_STEPS-1];
   logic [63:0] sq_r_in   [0:1][0:SQRT_STEPS-1];

   always_comb begin
      logic [63:0] v_cur, r_cur, bt, trial;
      for (int r = 0; r < 2; r++) begin
         for (int j = 0; j < SQRT_STEPS; j++) begin
            if (j == 0) begin
               v_cur = (r == 0) ? root_a_s11_ff : root_b_s11_ff;
               r_cur = '0;
            end else begin
               v_cur = sq_v_ff[r][j];
               r_cur = sq_r_ff[r][j];
            end
            bt    = 64'd1 << (62 - 2 * j);
            trial = r_cur + bt;
            if (v_cur >= trial) begin
               sq_v_in[r][j] = v_cur - trial;
               sq_r_in[r][j] = (r_cur >> 1) + bt;
            end else begin
               sq_v_in[r][j] = v_cur;
               sq_r_in[r][j] = r_cur >> 1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int r = 0; r < 2; r++) begin
            for (int j = 0; j < SQRT_STEPS; j++) begin
               sq_v_ff[r][j+1] <= sq_v_in[r][j];
               sq_r_ff[r][j+1] <= sq_r_in[r][j];
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Vectoring CORDIC: angle of (sqrt(1-a), sqrt(a)) in Q60
   // ------------------------------------------------------------------
   hdu_pkg::z_type vec_z;

   hdu_cordic #(
      .ITERATIONS (CORDIC_ITERATIONS),
      .VECTORING  (1'b1),
      .TAG_W      (1)
   ) u_vec (
      .clock   (clock),
      .enable  (pipe_en),
      .src_x   (hdu_pkg::xy_type'({sq_r_ff[1][SQRT_STEPS][30:0], 10'b0})),
      .src_y   (hdu_pkg::xy_type'({sq_r_ff[0][SQRT_STEPS][30:0], 10'b0})),
      .src_z   ('0),
      .src_tag (1'b0),
      .dst_x   (),
      .dst_y   (),
      .dst_z   (vec_z),
      .dst_tag ()
   );

   // ------------------------------------------------------------------
   // s12..out: angle to Q36, scale by radius, round to metres.
   // th36 carries the factor 2 of c = 2*atan2 via the Q35 shift below.
   // ------------------------------------------------------------------
   logic [63:0] th_pos, th_sum;
   logic [36:0] th36_in, th36_s12_ff;
   logic [41:0] rp_hi_s13_ff;
   logic [40:0] rp_lo_s13_ff;
   logic [60:0] dist_sum;
   logic [24:0] dist_in, dist_ff;

   always_comb begin
      th_pos   = vec_z[63] ? '0 : 64'(vec_z);
      th_sum   = th_pos + (64'd1 << 23);
      th36_in  = th_sum[60:24];
      dist_sum = 61'({rp_hi_s13_ff, 18'b0}) + 61'(rp_lo_s13_ff) + (61'd1 << 34);
      dist_in  = dist_sum[59:35];
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         th36_s12_ff  <= th36_in;
         rp_hi_s13_ff <= 42'(radius_ff) * 42'(th36_s12_ff[36:18]);
         rp_lo_s13_ff <= 41'(radius_ff) * 41'(th36_s12_ff[17:0]);
         dist_ff      <= dist_in;
      end
   end

   assign rsp_distance_metres = dist_ff;

endmodule

>>> dv/haversine_distance_checker.sv
// ----------------------------------------------------------------------------
// haversine_distance_checker
// Watches the item and result channels of the haversine distance unit,
// predicts each distance in the same fixed-point scheme and compares it
// with the result that comes out, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module haversine_distance_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [30:0] req_first_latitude,
   input  logic signed [31:0] req_first_longitude,
   input  logic signed [30:0] req_second_latitude,
   input  logic signed [31:0] req_second_longitude,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [24:0]        rsp_distance_metres,
   input  logic               csr_write_enable,
   input  logic [22:0]        csr_write_data,
   output int                 error_count,
   output int                 pending_count
);

   localparam int STEPS = 24;
   localparam bit [63:0] UNIT_Q60 = 64'd1 << 60;
   localparam longint ONE_Q30 = 64'sd1 << 30;

   bit [63:0]   arc_tab [STEPS];
   bit [63:0]   half_turn_q30;
   bit [63:0]   scale_q30;
   bit [22:0]   radius;
   bit [24:0]   distance_fifo [$];

   function automatic bit [63:0] arctan_inverse(bit [63:0] n);
      bit [63:0] p, acc, term, k;
      p = UNIT_Q60 / n;
      acc = 0;
      k = 0;
      while (p != 0) begin
         term = p / (2 * k + 1);
         if (k[0]) acc = acc - term;
         else acc = acc + term;
         p = p / n / n;
         k++;
      end
      return acc;
   endfunction

   function automatic bit [63:0] int_sqrt(bit [63:0] v);
      bit [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic longint round_shift(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clip_q30(longint v);
      if (v > ONE_Q30) return ONE_Q30;
      if (v < -ONE_Q30) return -ONE_Q30;
      return v;
   endfunction

   function automatic void rotate_turn(bit [31:0] ang, output longint co, output longint si);
      longint x, y, z, dx, dy, cc, ss;
      bit [63:0] r;
      r = {34'd0, ang[29:0]};
      z = longint'((r * half_turn_q30) >> 1);
      x = longint'(scale_q30 << 10);
      y = 0;
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(arc_tab[i]);
         end else begin
            x += dx; y -= dy; z += longint'(arc_tab[i]);
         end
      end
      cc = clip_q30(round_shift(x, 10));
      ss = clip_q30(round_shift(y, 10));
      case (ang[31:30])
         2'd0: begin co = cc;  si = ss;  end
         2'd1: begin co = -ss; si = cc;  end
         2'd2: begin co = -cc; si = -ss; end
         default: begin co = ss; si = -cc; end
      endcase
   endfunction

   function automatic bit [63:0] vector_arc(bit [63:0] xa, bit [63:0] ya);
      longint x, y, z, dx, dy;
      x = longint'(xa << 10);
      y = longint'(ya << 10);
      z = 0;
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y < 0) begin
            x -= dx; y += dy; z -= longint'(arc_tab[i]);
         end else begin
            x += dx; y -= dy; z += longint'(arc_tab[i]);
         end
      end
      return z < 0 ? 64'd0 : 64'(z);
   endfunction

   // 1e-7 degree to binary turns, scaled by 2^sh / 3.6e9, ties away from zero
   function automatic bit [31:0] degrees_to_turn(longint v, int sh);
      bit [63:0] mag;
      bit [31:0] t;
      mag = v < 0 ? 64'(-v) : 64'(v);
      t = 32'(((mag << sh) + 64'd1800000000) / 64'd3600000000);
      return v < 0 ? -t : t;
   endfunction

   function automatic bit [24:0] great_circle_metres(longint la1, longint lo1,
                                                     longint la2, longint lo2,
                                                     bit [22:0] rad);
      longint c1, c2, s1, s2, unused, t, u, a;
      bit [63:0] ya, xa, th36, prod;
      rotate_turn(degrees_to_turn(la1, 32), c1, unused);
      rotate_turn(degrees_to_turn(la2, 32), c2, unused);
      rotate_turn(degrees_to_turn(la2 - la1, 31), unused, s1);
      rotate_turn(degrees_to_turn(lo2 - lo1, 31), unused, s2);
      t = round_shift(c1 * c2, 30);
      u = round_shift(t * s2, 30);
      a = s1 * s1 + u * s2;
      if (a < 0) a = 0;
      if (a > longint'(UNIT_Q60)) a = longint'(UNIT_Q60);
      ya = int_sqrt(64'(a));
      xa = int_sqrt(UNIT_Q60 - 64'(a));
      th36 = (vector_arc(xa, ya) + (64'd1 << 23)) >> 24;
      prod = (64'(rad) * th36 + (64'd1 << 34)) >> 35;
      return prod[24:0];
   endfunction

   initial begin
      bit [63:0] kk;
      for (int i = 0; i < STEPS; i++)
         arc_tab[i] = (i == 0) ? arctan_inverse(2) + arctan_inverse(3)
                               : arctan_inverse(64'd1 << i);
      half_turn_q30 = (4 * arc_tab[0] + (64'd1 << 29)) >> 30;
      kk = UNIT_Q60;
      for (int i = 0; i < STEPS; i++)
         kk = kk - kk / ((64'd1 << (2 * i)) + 1);
      scale_q30 = int_sqrt(kk);
      error_count = 0;
      radius = 23'd6371000;
   end

   assign pending_count = distance_fifo.size();

   always @(posedge clock) begin
      bit [24:0] want;
      if (reset) begin
         radius <= 23'd6371000;
         distance_fifo.delete();
      end else begin
         if (csr_write_enable) radius <= csr_write_data;
         if (req_valid && !req_stall)
            distance_fifo.push_back(great_circle_metres(
               longint'(req_first_latitude), longint'(req_first_longitude),
               longint'(req_second_latitude), longint'(req_second_longitude),
               radius));
         if (rsp_valid && !rsp_stall) begin
            if (distance_fifo.size() == 0) begin
               $display("%0t: unexpected distance %0d", $time, rsp_distance_metres);
               error_count++;
            end else begin
               want = distance_fifo.pop_front();
               if (want !== rsp_distance_metres) begin
                  $display("%0t: distance_metres expected %0d actual %0d",
                           $time, want, rsp_distance_metres);
                  error_count++;
               end
            end
         end
      end
   end

endmodule

>>> dv/haversine_distance_unit_tb.sv
// ----------------------------------------------------------------------------
// haversine_distance_unit_tb
// Drives point pairs into the haversine distance unit across several radius
// settings, with random gaps and stalls on both sides; a checker module
// predicts and compares every distance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module haversine_distance_unit_tb;

   localparam int LATENCY     = 95;
   localparam int SETTLE      = LATENCY + 25;   // latency plus margin
   localparam int STALL_LIMIT = 3000;  // cycles without any accept

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic signed [30:0] req_first_latitude = 0;
   logic signed [31:0] req_first_longitude = 0;
   logic signed [30:0] req_second_latitude = 0;
   logic signed [31:0] req_second_longitude = 0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic [24:0]        rsp_distance_metres;
   logic               csr_write_enable = 0;
   logic [22:0]        csr_write_data = 0;

   int  error_count;
   int  pending_count;
   bit  idling_on = 1;
   bit  want_long_hold = 0;
   bit  long_hold_done = 0;
   int  long_hold_left = 0;
   int  burst_left = 0;
   int  quiet_cycles = 0;

   always #5 clock = ~clock;

   haversine_distance_unit DUT (
      .clock, .reset,
      .req_valid, .req_stall,
      .req_first_latitude, .req_first_longitude,
      .req_second_latitude, .req_second_longitude,
      .rsp_valid, .rsp_stall, .rsp_distance_metres,
      .csr_write_enable, .csr_write_data
   );

   haversine_distance_checker checker_i (
      .clock, .reset,
      .req_valid, .req_stall,
      .req_first_latitude, .req_first_longitude,
      .req_second_latitude, .req_second_longitude,
      .rsp_valid, .rsp_stall, .rsp_distance_metres,
      .csr_write_enable, .csr_write_data,
      .error_count, .pending_count
   );

   // Result side: short random stall bursts, plus one long hold-off so the
   // pipe backs up and pushes stall onto the item side.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else if (want_long_hold && !long_hold_done) begin
         rsp_stall <= 1;
         long_hold_left <= 400;
         long_hold_done <= 1;
      end else if (long_hold_left > 0) begin
         rsp_stall <= 1;
         long_hold_left <= long_hold_left - 1;
      end else if (burst_left > 0) begin
         rsp_stall <= 1;
         burst_left <= burst_left - 1;
      end else begin
         rsp_stall <= 0;
         if (idling_on && $urandom_range(9) == 0) burst_left <= $urandom_range(8, 1);
      end
   end

   // Watchdog: nothing moving on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[haversine_distance_unit] ERROR");
         $finish;
      end
   end

   // Present one item and hold it until accepted; stall is stable by negedge.
   task automatic offer_points(input logic [30:0] la1, input logic [31:0] lo1,
                               input logic [30:0] la2, input logic [31:0] lo2);
      bit taken;
      int gap;
      req_first_latitude   <= la1;
      req_first_longitude  <= lo1;
      req_second_latitude  <= la2;
      req_second_longitude <= lo2;
      req_valid            <= 1;
      taken = 0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
      // random sender gap right after an accept
      if (idling_on && $urandom_range(7) == 0) begin
         gap = $urandom_range(8, 1);
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Radius write only with the pipe empty
   task automatic set_radius(input logic [22:0] r);
      req_valid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_write_enable <= 1;
      csr_write_data   <= r;
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   function automatic logic [30:0] any_latitude();
      return 31'(longint'($urandom_range(1800000000)) - 900000000);
   endfunction

   function automatic logic [31:0] any_longitude();
      return 32'(longint'($urandom_range(32'd3600000000)) - 1800000000);
   endfunction

   // Mostly in-range pairs, some nearby pairs (tiny differences), some raw bits
   task automatic random_points(input int count);
      logic [30:0] la1, la2;
      logic [31:0] lo1, lo2;
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         la1 = any_latitude();
         lo1 = any_longitude();
         if (pick < 65) begin
            la2 = any_latitude();
            lo2 = any_longitude();
         end else if (pick < 85) begin
            la2 = la1 + 31'($urandom_range(2000) - 1000);
            lo2 = lo1 + 32'($urandom_range(200000) - 100000);
         end else begin
            la1 = 31'($urandom); lo1 = 32'($urandom);
            la2 = 31'($urandom); lo2 = 32'($urandom);
         end
         offer_points(la1, lo1, la2, lo2);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: identical points, antipodes, poles, field extremes, wrap-around
      offer_points(0, 0, 0, 0);
      offer_points(0, 0, 0, 1800000000);
      offer_points(0, -1800000000, 0, 1800000000);
      offer_points(900000000, 0, -900000000, 0);
      offer_points(900000000, 123456789, 900000000, -987654321);
      offer_points(-900000000, 0, -900000000, 1800000000);
      offer_points(0, 0, 1, 0);
      offer_points(0, 0, 0, 1);
      offer_points(0, 0, 0, -1);
      offer_points(515000000, -1200000, 487000000, 23000000);
      offer_points(31'h3FFFFFFF, 32'h7FFFFFFF, 31'h40000000, 32'h80000000);
      offer_points(31'h40000000, 32'h80000000, 31'h3FFFFFFF, 32'h7FFFFFFF);
      offer_points(31'h7FFFFFFF, 32'hFFFFFFFF, 31'h7FFFFFFF, 32'hFFFFFFFF);
      offer_points(31'h7FFFFFFF, 32'hFFFFFFFF, 0, 0);
      offer_points(0, 32'h80000000, 0, 32'h7FFFFFFF);
      offer_points(450000000, 900000000, -450000000, -900000000);
      offer_points(100000000, 1799999999, 100000000, -1799999999);
      offer_points(-899999999, 0, 899999999, 0);

      set_radius(23'd6000000);
      random_points(250);

      // Long receiver hold while the sender keeps offering
      set_radius(23'd7000000);
      want_long_hold = 1;
      random_points(250);

      set_radius(23'h7FFFFF);
      offer_points(0, 0, 0, 1800000000);
      random_points(150);

      set_radius(23'd0);
      offer_points(900000000, 0, -900000000, 0);
      random_points(60);

      set_radius(23'd6371000);
      random_points(200);

      // closing stretch back to back, no idling
      idling_on = 0;
      random_points(170);
      req_valid <= 0;

      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0)
         $display("[haversine_distance_unit] OK");
      else
         $display("[haversine_distance_unit] ERROR");
      $finish;
   end

endmodule
